>>> hdl/baro_pressure_temp_compensation_assert.svh
// Assertion macros shared by the compensation block
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define BPTC_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define BPTC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/bptc_pkg.sv
// Shared types, constants and arithmetic helpers for the compensation block
`default_nettype none
package bptc_pkg;

   localparam int RAW_W       = 24;
   localparam int TEMP_W      = 28;
   localparam int PRES_W      = 40;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int DIV_W       = 8;
   localparam int SHIFT_W     = 5;
   localparam int DIV_STEPS   = 6;
   localparam int MID_DEPTH   = 16;
   localparam int OUT_DEPTH   = 32;
   localparam int BACK_LAT    = 15;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_COEF     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_OFS_COEF = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_TMP_COEF = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_HI_COEF  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_OSR      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_OSR      = 3'd5;

   localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] TEMP_MAX = (64'sd1 <<< (TEMP_W - 1)) - 64'sd1;
   localparam logic signed [63:0] TEMP_MIN = -(64'sd1 <<< (TEMP_W - 1));
   localparam logic signed [63:0] PRES_MAX = (64'sd1 <<< (PRES_W - 1)) - 64'sd1;
   localparam logic signed [63:0] PRES_MIN = -(64'sd1 <<< (PRES_W - 1));

   typedef struct packed {
      logic signed [11:0] c0;
      logic signed [11:0] c1;
      logic signed [19:0] c00;
      logic signed [19:0] c10;
      logic signed [15:0] c01;
      logic signed [15:0] c11;
      logic signed [15:0] c20;
      logic signed [15:0] c21;
      logic signed [15:0] c30;
   } coef_type;

   // scale factor k = d * 2^s; d is odd
   function automatic logic [DIV_W-1:0] scale_divisor(input logic [2:0] code);
      logic [DIV_W-1:0] d;
      case (code)
         3'd0: d = 8'd1;
         3'd1: d = 8'd3;
         3'd2: d = 8'd7;
         3'd3: d = 8'd15;
         3'd4: d = 8'd31;
         3'd5: d = 8'd63;
         3'd6: d = 8'd127;
         3'd7: d = 8'd255;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

   function automatic logic [SHIFT_W-1:0] scale_shift(input logic [2:0] code);
      return code[2] ? 5'd13 : 5'd19;
   endfunction

   function automatic int div_stages(input int xw);
      return (xw + DIV_STEPS - 1) / DIV_STEPS;
   endfunction

   // 64-bit add, clamped at the signed bounds
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   // divide by 2^sh, ties away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int sh);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? 64'(-v) : 64'(v);
      r   = (mag >> sh) + ((mag >> (sh - 1)) & 64'd1);
      return v[63] ? -signed'(r) : signed'(r);
   endfunction

endpackage
`default_nettype wire

>>> hdl/baro_pressure_temp_compensation.sv
// Barometric pressure and temperature compensation, top level
//
// Accepts one raw temperature/pressure pair per cycle while req_full is low and
// returns, in order, the compensated temperature (Q.8) and pressure (Q.4,
// pascal) plus a clip flag. A front section scales both samples by the
// oversampling factor in a pipelined long divider (six quotient bits per
// stage), a 16-entry queue decouples it from the back section, which evaluates
// the polynomial in a 16-stage chain of pipelined multipliers, and a 32-entry
// result queue holds finished transactions until popped. Sustained rate is one
// transaction per cycle while results are popped; a transaction passes the
// input capture, prescale, divider and sign-restore registers, the mid queue,
// the back-end multiplier chain and the result queue. req_full rises only
// when the front has 16 transactions in flight or queued; coefficient and
// oversampling registers must be written only while the block is idle.
`default_nettype none
`include "baro_pressure_temp_compensation_assert.svh"
module baro_pressure_temp_compensation #(
   parameter int SCALE_FRAC_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic signed [bptc_pkg::RAW_W-1:0]      req_raw_temperature,
   input  wire logic signed [bptc_pkg::RAW_W-1:0]      req_raw_pressure,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic signed [bptc_pkg::TEMP_W-1:0]          rsp_temperature_out,
   output logic signed [bptc_pkg::PRES_W-1:0]          rsp_pressure_out,
   output logic                                        rsp_saturated,
   input  wire logic                                   csr_write_enable,
   input  wire logic [bptc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [bptc_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   localparam int F    = SCALE_FRAC_BITS;
   localparam int SW   = F + 8;
   localparam int TW   = bptc_pkg::TEMP_W;
   localparam int PW   = bptc_pkg::PRES_W;
   localparam int MQW  = 2 * SW;
   localparam int OQW  = TW + PW + 1;
   localparam int MCW  = $clog2(bptc_pkg::MID_DEPTH + 1);
   localparam int OCW  = $clog2(bptc_pkg::OUT_DEPTH + 1);

   logic [23:0] temp_coef_ff;
   logic [39:0] pres_ofs_coef_ff;
   logic [31:0] pres_tmp_coef_ff;
   logic [47:0] pres_hi_coef_ff;
   logic [2:0]  pres_osr_ff;
   logic [2:0]  temp_osr_ff;
   bptc_pkg::coef_type coef;

   logic                 req_accept;
   logic                 front_valid;
   logic signed [SW-1:0] front_tsc, front_psc;
   logic                 mid_empty;
   logic [MQW-1:0]       mid_head;
   logic                 back_issue;
   logic                 back_valid;
   logic signed [TW-1:0] back_temp;
   logic signed [PW-1:0] back_pres;
   logic                 back_sat;
   logic                 rsp_accept;
   logic [OQW-1:0]       out_head;
   logic [MCW-1:0]       front_reserved_ff;
   logic [OCW-1:0]       back_reserved_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coef_ff     <= '0;
         pres_ofs_coef_ff <= '0;
         pres_tmp_coef_ff <= '0;
         pres_hi_coef_ff  <= '0;
         pres_osr_ff      <= '0;
         temp_osr_ff      <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            bptc_pkg::CSR_TEMP_COEF:     temp_coef_ff     <= csr_write_data[23:0];
            bptc_pkg::CSR_PRES_OFS_COEF: pres_ofs_coef_ff <= csr_write_data[39:0];
            bptc_pkg::CSR_PRES_TMP_COEF: pres_tmp_coef_ff <= csr_write_data[31:0];
            bptc_pkg::CSR_PRES_HI_COEF:  pres_hi_coef_ff  <= csr_write_data[47:0];
            bptc_pkg::CSR_PRES_OSR:      pres_osr_ff      <= csr_write_data[2:0];
            bptc_pkg::CSR_TEMP_OSR:      temp_osr_ff      <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // coefficient unpacking
   assign coef.c0  = signed'(temp_coef_ff[23:12]);
   assign coef.c1  = signed'(temp_coef_ff[11:0]);
   assign coef.c00 = signed'(pres_ofs_coef_ff[39:20]);
   assign coef.c10 = signed'(pres_ofs_coef_ff[19:0]);
   assign coef.c01 = signed'(pres_tmp_coef_ff[31:16]);
   assign coef.c11 = signed'(pres_tmp_coef_ff[15:0]);
   assign coef.c20 = signed'(pres_hi_coef_ff[47:32]);
   assign coef.c21 = signed'(pres_hi_coef_ff[31:16]);
   assign coef.c30 = signed'(pres_hi_coef_ff[15:0]);

   // credit counters: front covers pipeline + mid queue, back covers pipeline + result queue
   assign req_full   = (front_reserved_ff == MCW'(bptc_pkg::MID_DEPTH));
   assign req_accept = req_push & ~req_full;
   assign back_issue = ~mid_empty & (back_reserved_ff != OCW'(bptc_pkg::OUT_DEPTH));
   assign rsp_accept = rsp_pop & ~rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_reserved_ff <= '0;
         back_reserved_ff  <= '0;
      end else begin
         front_reserved_ff <= front_reserved_ff + MCW'(req_accept) - MCW'(back_issue);
         back_reserved_ff  <= back_reserved_ff + OCW'(back_issue) - OCW'(rsp_accept);
      end
   end

   bptc_front #(.F(F)) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_accept),
      .raw_temperature (req_raw_temperature),
      .raw_pressure    (req_raw_pressure),
      .temp_code       (temp_osr_ff),
      .pres_code       (pres_osr_ff),
      .out_valid       (front_valid),
      .tsc             (front_tsc),
      .psc             (front_psc)
   );

   bptc_fifo #(.WIDTH(MQW), .DEPTH(bptc_pkg::MID_DEPTH)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data ({front_tsc, front_psc}),
      .pop       (back_issue),
      .empty     (mid_empty),
      .head_data (mid_head)
   );

   bptc_back #(.F(F)) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (back_issue),
      .tsc             (signed'(mid_head[MQW-1:SW])),
      .psc             (signed'(mid_head[SW-1:0])),
      .coef            (coef),
      .out_valid       (back_valid),
      .temperature_out (back_temp),
      .pressure_out    (back_pres),
      .saturated       (back_sat)
   );

   bptc_fifo #(.WIDTH(OQW), .DEPTH(bptc_pkg::OUT_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data ({back_temp, back_pres, back_sat}),
      .pop       (rsp_accept),
      .empty     (rsp_empty),
      .head_data (out_head)
   );

   assign rsp_temperature_out = signed'(out_head[OQW-1:PW+1]);
   assign rsp_pressure_out    = signed'(out_head[PW:1]);
   assign rsp_saturated       = out_head[0];

   // credit and queue consistency
   `BPTC_ASSERT_HOLDS(a_front_credit_bound, clock, reset,
      front_reserved_ff <= MCW'(bptc_pkg::MID_DEPTH), "front credit count overflow")
   `BPTC_ASSERT_HOLDS(a_back_credit_bound, clock, reset,
      back_reserved_ff <= OCW'(bptc_pkg::OUT_DEPTH), "back credit count overflow")
   `BPTC_ASSERT_IMPLIES(a_mid_has_credit, clock, reset,
      !mid_empty, front_reserved_ff != '0, "mid queue holds an uncounted transaction")
   `BPTC_ASSERT_IMPLIES(a_rsp_has_credit, clock, reset,
      !rsp_empty, back_reserved_ff != '0, "result queue holds an uncounted transaction")
   `BPTC_ASSERT_IMPLIES(a_back_out_credit, clock, reset,
      back_valid, back_reserved_ff != '0, "back pipeline result without credit")
endmodule
`default_nettype wire

>>> hdl/bptc_delay.sv
// Fixed-length register delay line for pipeline alignment
`default_nettype none
module bptc_delay #(
   parameter int W = 8,
   parameter int N = 1
) (
   input  wire logic         clock,
   input  wire logic [W-1:0] din,
   output logic [W-1:0]      dout
);
   logic [W-1:0] pipe_ff [N];

   always_ff @(posedge clock) begin
      pipe_ff[0] <= din;
      for (int i = 1; i < N; i++) begin
         pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   assign dout = pipe_ff[N-1];
endmodule
`default_nettype wire

>>> hdl/bptc_fifo.sv
// Small register FIFO; the head entry is presented combinationally
`default_nettype none
module bptc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      head_data
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff;
   logic [AW:0]      rd_ptr_ff;

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) data_ff[wr_ptr_ff[AW-1:0]] <= push_data;
   end

   assign empty     = (wr_ptr_ff == rd_ptr_ff);
   assign head_data = data_ff[rd_ptr_ff[AW-1:0]];
endmodule
`default_nettype wire

>>> hdl/bptc_mulr.sv
// Three-stage signed multiply, round-shift (ties away from zero), clamp to 64 bits
`default_nettype none
module bptc_mulr #(
   parameter int WA = 32,
   parameter int WB = 32,
   parameter int SH = 0
) (
   input  wire logic                 clock,
   input  wire logic signed [WA-1:0] a,
   input  wire logic signed [WB-1:0] b,
   output logic signed [63:0]        p
);
   localparam int AL = WA / 2;
   localparam int AH = WA - AL;
   localparam int BL = WB / 2;
   localparam int BH = WB - BL;
   localparam int PW = WA + WB;
   localparam int MW = (PW + 1 > 65) ? PW + 1 : 65;
   localparam logic [MW-1:0] RND     = (MW'(1) << SH) >> 1;
   localparam logic [MW-1:0] MAG_MAX = MW'(64'h7FFF_FFFF_FFFF_FFFF);

   logic [WA-1:0] ua;
   logic [WB-1:0] ub;
   logic [AL+BL-1:0] pp00_ff;
   logic [AL+BH-1:0] pp01_ff;
   logic [AH+BL-1:0] pp10_ff;
   logic [AH+BH-1:0] pp11_ff;
   logic             neg1_ff;
   logic [PW-1:0]    sum_ff;
   logic             neg2_ff;
   logic [MW-1:0]    rs;
   logic [MW-1:0]    shv;
   logic signed [63:0] p_ff;

   assign ua = a[WA-1] ? WA'(-a) : WA'(a);
   assign ub = b[WB-1] ? WB'(-b) : WB'(b);

   // stage 1: partial products on magnitudes
   always_ff @(posedge clock) begin
      pp00_ff <= (AL+BL)'(ua[AL-1:0]) * (AL+BL)'(ub[BL-1:0]);
      pp01_ff <= (AL+BH)'(ua[AL-1:0]) * (AL+BH)'(ub[WB-1:BL]);
      pp10_ff <= (AH+BL)'(ua[WA-1:AL]) * (AH+BL)'(ub[BL-1:0]);
      pp11_ff <= (AH+BH)'(ua[WA-1:AL]) * (AH+BH)'(ub[WB-1:BL]);
      neg1_ff <= a[WA-1] ^ b[WB-1];
   end

   // stage 2: combine; a_lo*b_hi weighs 2^BL, a_hi*b_lo weighs 2^AL
   always_ff @(posedge clock) begin
      sum_ff  <= PW'(pp00_ff) + (PW'(pp01_ff) << BL) + (PW'(pp10_ff) << AL)
                 + (PW'(pp11_ff) << (AL + BL));
      neg2_ff <= neg1_ff;
   end

   // stage 3: round, shift, clamp, apply sign
   assign rs  = MW'(sum_ff) + RND;
   assign shv = rs >> SH;

   always_ff @(posedge clock) begin
      if (shv > MAG_MAX) begin
         p_ff <= neg2_ff ? bptc_pkg::S64_MIN : bptc_pkg::S64_MAX;
      end else begin
         p_ff <= neg2_ff ? -signed'(shv[63:0]) : signed'(shv[63:0]);
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

>>> hdl/bptc_div.sv
// Pipelined restoring division of an unsigned word by an 8-bit odd divisor
`default_nettype none
module bptc_div #(
   parameter int XW = 35
) (
   input  wire logic                       clock,
   input  wire logic [XW-1:0]              x_in,
   input  wire logic [bptc_pkg::DIV_W-1:0] d_in,
   output logic [XW-1:0]                   q_out
);
   localparam int DW    = bptc_pkg::DIV_W;
   localparam int STEPS = bptc_pkg::DIV_STEPS;
   localparam int NS    = bptc_pkg::div_stages(XW);

   // x holds remaining dividend bits above, quotient bits shifted in below
   logic [XW-1:0] x_ff [NS];
   logic [DW-1:0] r_ff [NS];
   logic [DW-1:0] d_ff [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [XW-1:0] x_src;
      logic [DW-1:0] r_src;
      logic [DW-1:0] d_src;
      logic [XW-1:0] x_nxt;
      logic [DW-1:0] r_nxt;

      if (g == 0) begin : g_first
         assign x_src = x_in;
         assign r_src = '0;
         assign d_src = d_in;
      end else begin : g_next
         assign x_src = x_ff[g-1];
         assign r_src = r_ff[g-1];
         assign d_src = d_ff[g-1];
      end

      // up to STEPS quotient bits per stage
      always_comb begin
         logic [DW:0] r2;
         x_nxt = x_src;
         r_nxt = r_src;
         r2    = '0;
         for (int j = 0; j < STEPS; j++) begin
            if (g * STEPS + j < XW) begin
               r2    = {r_nxt, x_nxt[XW-1]};
               x_nxt = {x_nxt[XW-2:0], 1'b0};
               if (r2 >= {1'b0, d_src}) begin
                  r2       = r2 - {1'b0, d_src};
                  x_nxt[0] = 1'b1;
               end
               r_nxt = r2[DW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         x_ff[g] <= x_nxt;
         r_ff[g] <= r_nxt;
         d_ff[g] <= d_src;
      end
   end

   assign q_out = x_ff[NS-1];
endmodule
`default_nettype wire

>>> hdl/bptc_front.sv
// Front end: takes raw sample pairs and scales them to signed Q.F by the oversampling factor
`default_nettype none
module bptc_front #(
   parameter int F = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire logic signed [bptc_pkg::RAW_W-1:0]  raw_temperature,
   input  wire logic signed [bptc_pkg::RAW_W-1:0]  raw_pressure,
   input  wire logic [2:0]                         temp_code,
   input  wire logic [2:0]                         pres_code,
   output logic                                    out_valid,
   output logic signed [F+7:0]                     tsc,
   output logic signed [F+7:0]                     psc
);
   localparam int RW = bptc_pkg::RAW_W;
   localparam int XW = F + 11;
   localparam int NW = F + RW;
   localparam int SW = F + 8;
   localparam int NS = bptc_pkg::div_stages(XW);

   logic signed [RW-1:0] rawt_a_ff, rawp_a_ff;
   logic                 va_ff;
   logic [RW-1:0]        magt, magp;
   logic [NW-1:0]        nt, np;
   logic [bptc_pkg::DIV_W-1:0]   dt, dp;
   logic [bptc_pkg::SHIFT_W-1:0] st, sp;
   logic [XW-1:0]        xt_b_ff, xp_b_ff;
   logic [bptc_pkg::DIV_W-1:0] dt_b_ff, dp_b_ff;
   logic [1:0]           neg_b_ff;
   logic                 vb_ff;
   logic [XW-1:0]        qt, qp;
   logic [1:0]           neg_d;
   logic [NS-1:0]        vdiv_ff;
   logic signed [SW-1:0] tsc_ff, psc_ff;
   logic                 vc_ff;

   // valid tracking through the front
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         vdiv_ff <= '0;
         vc_ff   <= 1'b0;
      end else begin
         va_ff   <= in_valid;
         vb_ff   <= va_ff;
         vdiv_ff <= {vdiv_ff[NS-2:0], vb_ff};
         vc_ff   <= vdiv_ff[NS-1];
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      rawt_a_ff <= raw_temperature;
      rawp_a_ff <= raw_pressure;
   end

   // round(|raw| * 2^F / (d * 2^s)) = floor(((|raw| << F) + k/2) >> s) / d
   assign dt   = bptc_pkg::scale_divisor(temp_code);
   assign dp   = bptc_pkg::scale_divisor(pres_code);
   assign st   = bptc_pkg::scale_shift(temp_code);
   assign sp   = bptc_pkg::scale_shift(pres_code);
   assign magt = rawt_a_ff[RW-1] ? RW'(-rawt_a_ff) : RW'(rawt_a_ff);
   assign magp = rawp_a_ff[RW-1] ? RW'(-rawp_a_ff) : RW'(rawp_a_ff);
   assign nt   = {magt, {F{1'b0}}} + (NW'(dt) << (st - 1'b1));
   assign np   = {magp, {F{1'b0}}} + (NW'(dp) << (sp - 1'b1));

   always_ff @(posedge clock) begin
      xt_b_ff  <= XW'(nt >> st);
      xp_b_ff  <= XW'(np >> sp);
      dt_b_ff  <= dt;
      dp_b_ff  <= dp;
      neg_b_ff <= {rawt_a_ff[RW-1], rawp_a_ff[RW-1]};
   end

   bptc_div #(.XW(XW)) u_div_t (
      .clock (clock),
      .x_in  (xt_b_ff),
      .d_in  (dt_b_ff),
      .q_out (qt)
   );

   bptc_div #(.XW(XW)) u_div_p (
      .clock (clock),
      .x_in  (xp_b_ff),
      .d_in  (dp_b_ff),
      .q_out (qp)
   );

   bptc_delay #(.W(2), .N(NS)) u_dly_sign (
      .clock (clock),
      .din   (neg_b_ff),
      .dout  (neg_d)
   );

   // restore sign
   always_ff @(posedge clock) begin
      tsc_ff <= neg_d[1] ? -signed'(qt[SW-1:0]) : signed'(qt[SW-1:0]);
      psc_ff <= neg_d[0] ? -signed'(qp[SW-1:0]) : signed'(qp[SW-1:0]);
   end

   assign out_valid = vc_ff;
   assign tsc       = tsc_ff;
   assign psc       = psc_ff;
endmodule
`default_nettype wire

>>> hdl/bptc_back.sv
// Back end: temperature line and pressure polynomial over a fixed-latency multiplier pipeline
`default_nettype none
module bptc_back #(
   parameter int F = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire logic signed [F+7:0]                tsc,
   input  wire logic signed [F+7:0]                psc,
   input  wire bptc_pkg::coef_type                 coef,
   output logic                                    out_valid,
   output logic signed [bptc_pkg::TEMP_W-1:0]      temperature_out,
   output logic signed [bptc_pkg::PRES_W-1:0]      pressure_out,
   output logic                                    saturated
);
   localparam int SW  = F + 8;
   localparam int TW  = bptc_pkg::TEMP_W;
   localparam int PW  = bptc_pkg::PRES_W;
   localparam int LAT = bptc_pkg::BACK_LAT;

   logic [LAT:0]         v_ff;
   logic signed [SW-1:0] tsc0_ff, psc0_ff;
   logic signed [SW-1:0] psc_d4, psc_d8;
   logic signed [63:0]   m_c30, m_c21, m_t01, m_c1, m_tp, m_a, m_q3, m_p;
   logic signed [63:0]   a_ff, q3in_ff, tsum_ff, tp_ff, q2_ff;
   logic signed [63:0]   p1_ff, p2_ff, p3_ff, t01_d, q3_d;
   logic signed [63:0]   tr, pr;
   logic signed [TW-1:0] tout_ff;
   logic                 tclip_ff;
   logic [TW:0]          temp_d;
   logic signed [PW-1:0] pout_ff;
   logic                 pclip_ff;

   // valid bit per stage, entry register is stage 0
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[LAT-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      tsc0_ff <= tsc;
      psc0_ff <= psc;
   end

   // first rank of products
   bptc_mulr #(.WA(SW), .WB(16), .SH(0)) u_mul_c30 (
      .clock(clock), .a(psc0_ff), .b(coef.c30), .p(m_c30));
   bptc_mulr #(.WA(SW), .WB(16), .SH(0)) u_mul_c21 (
      .clock(clock), .a(psc0_ff), .b(coef.c21), .p(m_c21));
   bptc_mulr #(.WA(SW), .WB(16), .SH(0)) u_mul_c01 (
      .clock(clock), .a(tsc0_ff), .b(coef.c01), .p(m_t01));
   bptc_mulr #(.WA(SW), .WB(12), .SH(0)) u_mul_c1 (
      .clock(clock), .a(tsc0_ff), .b(coef.c1), .p(m_c1));
   bptc_mulr #(.WA(SW), .WB(SW), .SH(F)) u_mul_tp (
      .clock(clock), .a(tsc0_ff), .b(psc0_ff), .p(m_tp));

   // stage 4: constant terms added
   always_ff @(posedge clock) begin
      a_ff    <= bptc_pkg::sat_add(64'(coef.c20) <<< F, m_c30);
      q3in_ff <= bptc_pkg::sat_add(64'(coef.c11) <<< F, m_c21);
      tsum_ff <= bptc_pkg::sat_add(64'(coef.c0) <<< (F - 1), m_c1);
      tp_ff   <= m_tp;
   end

   bptc_delay #(.W(SW), .N(4)) u_dly_psc4 (.clock(clock), .din(psc0_ff), .dout(psc_d4));
   bptc_delay #(.W(SW), .N(4)) u_dly_psc8 (.clock(clock), .din(psc_d4), .dout(psc_d8));

   // second rank
   bptc_mulr #(.WA(SW), .WB(64), .SH(F)) u_mul_a (
      .clock(clock), .a(psc_d4), .b(a_ff), .p(m_a));
   bptc_mulr #(.WA(64), .WB(64), .SH(F)) u_mul_q3 (
      .clock(clock), .a(tp_ff), .b(q3in_ff), .p(m_q3));

   // temperature: round to Q.8 and clamp
   assign tr = bptc_pkg::round_shift(tsum_ff, F - 8);

   always_ff @(posedge clock) begin
      if (tr > bptc_pkg::TEMP_MAX) begin
         tout_ff  <= TW'(bptc_pkg::TEMP_MAX);
         tclip_ff <= 1'b1;
      end else if (tr < bptc_pkg::TEMP_MIN) begin
         tout_ff  <= TW'(bptc_pkg::TEMP_MIN);
         tclip_ff <= 1'b1;
      end else begin
         tout_ff  <= TW'(tr);
         tclip_ff <= 1'b0;
      end
   end

   bptc_delay #(.W(TW + 1), .N(10)) u_dly_temp (
      .clock(clock), .din({tclip_ff, tout_ff}), .dout(temp_d));

   // stage 8: linear pressure term
   always_ff @(posedge clock) begin
      q2_ff <= bptc_pkg::sat_add(64'(coef.c10) <<< F, m_a);
   end

   bptc_mulr #(.WA(SW), .WB(64), .SH(F)) u_mul_p (
      .clock(clock), .a(psc_d8), .b(q2_ff), .p(m_p));

   bptc_delay #(.W(64), .N(9)) u_dly_t01 (.clock(clock), .din(m_t01), .dout(t01_d));
   bptc_delay #(.W(64), .N(6)) u_dly_q3 (.clock(clock), .din(m_q3), .dout(q3_d));

   // pressure sums in the order offset, temperature term, cross terms
   always_ff @(posedge clock) begin
      p1_ff <= bptc_pkg::sat_add(64'(coef.c00) <<< F, m_p);
      p2_ff <= bptc_pkg::sat_add(p1_ff, t01_d);
      p3_ff <= bptc_pkg::sat_add(p2_ff, q3_d);
   end

   // pressure: round to Q.4 and clamp
   assign pr = bptc_pkg::round_shift(p3_ff, F - 4);

   always_ff @(posedge clock) begin
      if (pr > bptc_pkg::PRES_MAX) begin
         pout_ff  <= PW'(bptc_pkg::PRES_MAX);
         pclip_ff <= 1'b1;
      end else if (pr < bptc_pkg::PRES_MIN) begin
         pout_ff  <= PW'(bptc_pkg::PRES_MIN);
         pclip_ff <= 1'b1;
      end else begin
         pout_ff  <= PW'(pr);
         pclip_ff <= 1'b0;
      end
   end

   assign out_valid       = v_ff[LAT];
   assign temperature_out = signed'(temp_d[TW-1:0]);
   assign pressure_out    = pout_ff;
   assign saturated       = temp_d[TW] | pclip_ff;
endmodule
`default_nettype wire

>>> dv/tb_baro_pressure_temp_compensation.sv
// Self-checking testbench for the barometric compensation block
`timescale 1ns / 100ps
`default_nettype none
module tb_baro_pressure_temp_compensation;

   localparam int SCALE_F = 24;
   localparam int SETTLE_CYCLES = 40;
   localparam int RAW_W = bptc_pkg::RAW_W;
   localparam int TEMP_W = bptc_pkg::TEMP_W;
   localparam int PRES_W = bptc_pkg::PRES_W;
   localparam int CSR_INDEX_W = bptc_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W = bptc_pkg::CSR_DATA_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sh7FFFFF;
   localparam logic signed [RAW_W-1:0] RAW_MIN = 24'sh800000;

   typedef struct {
      logic signed [RAW_W-1:0] temp;
      logic signed [RAW_W-1:0] pres;
   } sample_pair_type;

   typedef struct {
      logic signed [TEMP_W-1:0] temp;
      logic signed [PRES_W-1:0] pres;
      logic                     clipped;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [RAW_W-1:0] req_raw_temperature = '0;
   logic signed [RAW_W-1:0] req_raw_pressure = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [TEMP_W-1:0] rsp_temperature_out;
   logic signed [PRES_W-1:0] rsp_pressure_out;
   logic rsp_saturated;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   baro_pressure_temp_compensation DUT (.*);

   always #5 clock = ~clock;

   // model copy of the registers
   logic [23:0] m_tc = '0;
   logic [39:0] m_po = '0;
   logic [31:0] m_pt = '0;
   logic [47:0] m_ph = '0;
   logic [2:0]  m_posr = '0;
   logic [2:0]  m_tosr = '0;

   sample_pair_type pending_pairs[$];
   reading_type     expected_readings[$];
   int errors = 0;
   int pairs_sent = 0;
   int readings_checked = 0;
   int clipped_seen = 0;
   bit burst = 0;
   bit hold_sender = 0;
   bit push_taken = 0;
   bit pop_taken = 0;
   int send_gap = 0;
   int pop_gap = 0;

   // oversampling scale factors, codes 0..7
   localparam logic [63:0] K_TABLE [8] = '{64'd524288, 64'd1572864, 64'd3670016,
      64'd7864320, 64'd253952, 64'd516096, 64'd1040384, 64'd2088960};

   function automatic logic signed [63:0] mag_to_signed(input logic neg,
                                                        input logic [127:0] m);
      if (m > 128'h7FFF_FFFF_FFFF_FFFF)
         return neg ? bptc_pkg::S64_MIN : bptc_pkg::S64_MAX;
      return neg ? -signed'(m[63:0]) : signed'(m[63:0]);
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? bptc_pkg::S64_MIN : bptc_pkg::S64_MAX;
      return s[63:0];
   endfunction

   // a*b / 2^sh, ties away from zero, clamped to 64 bits
   function automatic logic signed [63:0] mul_rnd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input int sh);
      logic [127:0] p;
      p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
      return mag_to_signed(a[63] ^ b[63], p);
   endfunction

   function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] v,
                                                  input int sh);
      logic [63:0] m;
      m = abs64(v);
      return mag_to_signed(v[63], {64'd0, (m >> sh) + ((m >> (sh - 1)) & 64'd1)});
   endfunction

   function automatic logic signed [63:0] clip_to(input logic signed [63:0] v,
                                                  input int w, inout logic clipped);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         clipped = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clipped = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic logic signed [63:0] scale_raw(input logic signed [RAW_W-1:0] raw,
                                                    input logic [2:0] code);
      logic [63:0] k;
      logic [63:0] m;
      k = K_TABLE[code];
      m = abs64(64'(raw)) << SCALE_F;
      return mag_to_signed(raw[RAW_W-1], {64'd0, (m + k / 2) / k});
   endfunction

   // expected compensated reading for one sample pair
   function automatic reading_type compensate(input logic signed [RAW_W-1:0] raw_t,
                                              input logic signed [RAW_W-1:0] raw_p);
      logic signed [63:0] c0, c1, c00, c10, c01, c11, c20, c21, c30;
      logic signed [63:0] one, tsc, psc, t, p, a, q2, q3in, q3;
      logic clipped;
      reading_type r;
      one = 64'sd1 <<< SCALE_F;
      c0 = signed'(m_tc[23:12]);   c1 = signed'(m_tc[11:0]);
      c00 = signed'(m_po[39:20]);  c10 = signed'(m_po[19:0]);
      c01 = signed'(m_pt[31:16]);  c11 = signed'(m_pt[15:0]);
      c20 = signed'(m_ph[47:32]);  c21 = signed'(m_ph[31:16]);
      c30 = signed'(m_ph[15:0]);
      tsc = scale_raw(raw_t, m_tosr);
      psc = scale_raw(raw_p, m_posr);
      clipped = 1'b0;
      t = add_clamp(c0 * (one / 2), mul_rnd(tsc, c1, 0));
      t = clip_to(shr_rnd(t, SCALE_F - 8), TEMP_W, clipped);
      a = add_clamp(c20 * one, mul_rnd(psc, c30, 0));
      q2 = add_clamp(c10 * one, mul_rnd(psc, a, SCALE_F));
      q3in = add_clamp(c11 * one, mul_rnd(psc, c21, 0));
      q3 = mul_rnd(mul_rnd(tsc, psc, SCALE_F), q3in, SCALE_F);
      p = add_clamp(c00 * one, mul_rnd(psc, q2, SCALE_F));
      p = add_clamp(p, mul_rnd(tsc, c01, 0));
      p = add_clamp(p, q3);
      p = clip_to(shr_rnd(p, SCALE_F - 4), PRES_W, clipped);
      r.temp = t[TEMP_W-1:0];
      r.pres = p[PRES_W-1:0];
      r.clipped = clipped;
      return r;
   endfunction

   task automatic report(input string msg);
      $display("%0t ERROR %s", $realtime, msg);
      errors++;
   endtask

   function automatic int draw_gap();
      if (burst || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 13);
   endfunction

   // monitor: both handshakes at the rising edge
   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_readings.push_back(compensate(req_raw_temperature, req_raw_pressure));
            push_taken = 1;
            pairs_sent++;
         end
         if (rsp_pop && !rsp_empty) begin
            pop_taken = 1;
            if (expected_readings.size() == 0) begin
               report("result transaction with nothing expected");
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (rsp_saturated) clipped_seen++;
               if (rsp_temperature_out !== want.temp)
                  report($sformatf("temperature_out %0d, want %0d",
                                   rsp_temperature_out, want.temp));
               if (rsp_pressure_out !== want.pres)
                  report($sformatf("pressure_out %0d, want %0d", rsp_pressure_out, want.pres));
               if (rsp_saturated !== want.clipped)
                  report($sformatf("saturated %0b, want %0b", rsp_saturated, want.clipped));
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      logic nxt;
      sample_pair_type s;
      if (!reset) begin
         nxt = req_push;
         if (push_taken) begin
            nxt = 1'b0;
            push_taken = 0;
         end
         if (!nxt) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_pairs.size() > 0 && !hold_sender) begin
               s = pending_pairs.pop_front();
               req_raw_temperature <= s.temp;
               req_raw_pressure <= s.pres;
               nxt = 1'b1;
               send_gap = draw_gap();
            end
         end
         req_push <= nxt;
      end
   end

   // result consumer
   always @(negedge clock) begin
      logic nxt;
      if (!reset) begin
         nxt = rsp_pop;
         if (pop_taken) begin
            nxt = 1'b0;
            pop_taken = 0;
            pop_gap = draw_gap();
         end
         if (!nxt) begin
            if (pop_gap > 0) pop_gap--;
            else nxt = 1'b1;
         end
         rsp_pop <= nxt;
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_DATA_W-1:0];
      case (idx)
         bptc_pkg::CSR_TEMP_COEF:     m_tc = value[23:0];
         bptc_pkg::CSR_PRES_OFS_COEF: m_po = value[39:0];
         bptc_pkg::CSR_PRES_TMP_COEF: m_pt = value[31:0];
         bptc_pkg::CSR_PRES_HI_COEF:  m_ph = value[47:0];
         bptc_pkg::CSR_PRES_OSR:      m_posr = value[2:0];
         bptc_pkg::CSR_TEMP_OSR:      m_tosr = value[2:0];
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // wait for every sent transaction to come back, then let the pipeline settle
   task automatic drain();
      while (pending_pairs.size() > 0 || req_push || expected_readings.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [RAW_W-1:0] rand_raw();
      case ($urandom_range(0, 9))
         0: return RAW_MAX;
         1: return RAW_MIN;
         2: return 24'(signed'($urandom_range(0, 8)) - 4);
         3: return 24'($urandom_range(0, 4095));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] small16(input int lim);
      return 16'($urandom_range(0, 2 * lim) - lim);
   endfunction

   function automatic logic [11:0] small12(input int lim);
      return 12'($urandom_range(0, 2 * lim) - lim);
   endfunction

   task automatic add_pair(input logic signed [RAW_W-1:0] t,
                           input logic signed [RAW_W-1:0] p);
      sample_pair_type s;
      s.temp = t;
      s.pres = p;
      pending_pairs.push_back(s);
   endtask

   task automatic add_corner_pairs(input int n);
      logic signed [RAW_W-1:0] corners [4];
      corners = '{RAW_MIN, RAW_MAX, 24'sd0, -24'sd1};
      for (int i = 0; i < n; i++) add_pair(corners[i % 4], corners[(i / 4) % 4]);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset-value registers: everything should come out zero
      add_corner_pairs(4);
      drain();

      // typical calibration, extreme oversampling codes
      csr_write(bptc_pkg::CSR_TEMP_COEF, {12'sd204, -12'sd261});
      csr_write(bptc_pkg::CSR_PRES_OFS_COEF, {20'sd80000, -20'sd50000});
      csr_write(bptc_pkg::CSR_PRES_TMP_COEF, {-16'sd2000, 16'sd1200});
      csr_write(bptc_pkg::CSR_PRES_HI_COEF, {-16'sd9000, 16'sd25, -16'sd700});
      csr_write(bptc_pkg::CSR_PRES_OSR, 3'd0);
      csr_write(bptc_pkg::CSR_TEMP_OSR, 3'd7);
      csr_idle();
      add_corner_pairs(16);
      drain();

      // all coefficients at their positive limit
      csr_write(bptc_pkg::CSR_TEMP_COEF, {12'h7FF, 12'h7FF});
      csr_write(bptc_pkg::CSR_PRES_OFS_COEF, {20'h7FFFF, 20'h7FFFF});
      csr_write(bptc_pkg::CSR_PRES_TMP_COEF, {16'h7FFF, 16'h7FFF});
      csr_write(bptc_pkg::CSR_PRES_HI_COEF, {3{16'h7FFF}});
      csr_write(bptc_pkg::CSR_PRES_OSR, 3'd7);
      csr_write(bptc_pkg::CSR_TEMP_OSR, 3'd0);
      csr_idle();
      add_corner_pairs(4);
      drain();

      // all coefficients at their negative limit; spare indexes are ignored
      csr_write(bptc_pkg::CSR_TEMP_COEF, {12'h800, 12'h800});
      csr_write(bptc_pkg::CSR_PRES_OFS_COEF, {20'h80000, 20'h80000});
      csr_write(bptc_pkg::CSR_PRES_TMP_COEF, {16'h8000, 16'h8000});
      csr_write(bptc_pkg::CSR_PRES_HI_COEF, {3{16'h8000}});
      csr_write(CSR_SPARE_LO, '1);
      csr_write(CSR_SPARE_HI, '1);
      csr_idle();
      add_corner_pairs(4);
      drain();

      // random phases, walking the oversampling codes
      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 3 == 0) begin
            csr_write(bptc_pkg::CSR_TEMP_COEF, {$urandom, $urandom});
            csr_write(bptc_pkg::CSR_PRES_OFS_COEF, {$urandom, $urandom});
            csr_write(bptc_pkg::CSR_PRES_TMP_COEF, {$urandom, $urandom});
            csr_write(bptc_pkg::CSR_PRES_HI_COEF, {$urandom, $urandom});
         end else begin
            csr_write(bptc_pkg::CSR_TEMP_COEF, {small12(400), small12(400)});
            csr_write(bptc_pkg::CSR_PRES_OFS_COEF,
                      {4'(0), small16(30000), 4'(0), small16(30000)});
            csr_write(bptc_pkg::CSR_PRES_TMP_COEF, {small16(3000), small16(3000)});
            csr_write(bptc_pkg::CSR_PRES_HI_COEF,
                      {small16(12000), small16(200), small16(1500)});
         end
         csr_write(bptc_pkg::CSR_PRES_OSR, 3'(ph));
         csr_write(bptc_pkg::CSR_TEMP_OSR, 3'(ph * 3 + 1));
         if (ph == 4) csr_write(CSR_SPARE_LO, {$urandom, $urandom});
         csr_idle();
         burst = (ph % 4 == 1);
         for (int i = 0; i < 130; i++) begin
            add_pair(rand_raw(), rand_raw());
            // sender holds off mid-phase until the block has drained
            if (ph == 2 && i == 60) begin
               while (pending_pairs.size() > 0 || req_push) @(posedge clock);
               hold_sender = 1;
               while (expected_readings.size() > 0) @(posedge clock);
               hold_sender = 0;
            end
         end
         drain();
      end

      $display("Sent %0d sample pairs, checked %0d readings (%0d clipped) over 14 settings",
               pairs_sent, readings_checked, clipped_seen);
      if (errors == 0) begin
         $display("baro_pressure_temp_compensation: match");
      end else begin
         $display("baro_pressure_temp_compensation: mismatch");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("baro_pressure_temp_compensation: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

>>> baro_pressure_temp_compensation.f
+incdir+hdl
hdl/bptc_pkg.sv
hdl/bptc_delay.sv
hdl/bptc_fifo.sv
hdl/bptc_mulr.sv
hdl/bptc_div.sv
hdl/bptc_front.sv
hdl/bptc_back.sv
hdl/baro_pressure_temp_compensation.sv
dv/tb_baro_pressure_temp_compensation.sv
